>>> rtl/grs_pkg.sv
// shared types, sizes and codes of the route selector
package grs_pkg;

  localparam int PREFIX_COUNT = 1024;
  localparam int MAX_PATH_LEN = 64;
  localparam int IDX_W        = $clog2(PREFIX_COUNT);
  localparam int LEN_W        = $clog2(MAX_PATH_LEN + 2);

  localparam logic CMD_RECEIVED = 1'b0;
  localparam logic CMD_SEED     = 1'b1;

  localparam logic [2:0] REL_NONE     = 3'd0;
  localparam logic [2:0] REL_PROVIDER = 3'd1;
  localparam logic [2:0] REL_ORIGIN   = 3'd4;

  localparam logic [2:0] STATUS_NEW_BEST    = 3'd0;
  localparam logic [2:0] STATUS_KEPT        = 3'd1;
  localparam logic [2:0] STATUS_LOOP_DROP   = 3'd2;
  localparam logic [2:0] STATUS_SEEDED_KEPT = 3'd3;
  localparam logic [2:0] STATUS_SEED_STORED = 3'd4;
  localparam logic [2:0] STATUS_SEED_CONFL  = 3'd5;
  localparam logic [2:0] STATUS_TOO_LONG    = 3'd6;

  typedef struct packed {
    logic        command;
    logic [9:0]  prefix_index;
    logic [2:0]  relationship;
    logic [31:0] path_asn;
    logic        last_element;
  } item_t;

  typedef struct packed {
    logic [9:0]  result_prefix;
    logic [2:0]  status;
    logic [2:0]  best_relationship;
    logic [6:0]  best_path_length;
    logic [31:0] best_neighbor_asn;
  } result_t;

  typedef struct packed {
    logic             valid;
    logic             seeded;
    logic [2:0]       rel;
    logic [LEN_W-1:0] len;
    logic [31:0]      nbr;
  } route_entry_t;

  // summary of one finished announcement
  typedef struct packed {
    logic             command;
    logic [9:0]       prefix;
    logic [2:0]       rel;
    logic [LEN_W-1:0] len;
    logic             loop_seen;
    logic [31:0]      first_asn;
    logic [31:0]      second_asn;
  } path_info_t;

endpackage

>>> rtl/grs_route_ram.sv
// route table memory, one write port and one registered read port
module grs_route_ram (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [grs_pkg::IDX_W-1:0]  wr_addr,
  input  grs_pkg::route_entry_t      wr_data,
  input  logic                       rd_en,
  input  logic [grs_pkg::IDX_W-1:0]  rd_addr,
  output grs_pkg::route_entry_t      rd_data
);
  import grs_pkg::*;

  route_entry_t mem [PREFIX_COUNT];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/grs_path_collector.sv
// collects the path elements of one announcement
module grs_path_collector (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  grs_pkg::item_t     item,
  input  logic [31:0]        own_asn,
  output logic               first_elem,
  output grs_pkg::path_info_t info
);
  import grs_pkg::*;

  logic [LEN_W-1:0] count;
  logic [LEN_W-1:0] count_inc;
  logic             loop_next;
  logic [2:0]       rel_clamped;

  assign first_elem = (count == '0);
  assign count_inc  = (count <= LEN_W'(MAX_PATH_LEN)) ? count + 1'b1 : count;
  assign loop_next  = (first_elem ? 1'b0 : info.loop_seen) | (item.path_asn == own_asn);

  // relationship clamp into provider..origin
  always_comb begin
    if (item.relationship < REL_PROVIDER) begin
      rel_clamped = REL_PROVIDER;
    end else if (item.relationship > REL_ORIGIN) begin
      rel_clamped = REL_ORIGIN;
    end else begin
      rel_clamped = item.relationship;
    end
  end

  // element counter
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= item.last_element ? '0 : count_inc;
    end
  end

  // latched announcement fields
  always_ff @(posedge clk) begin
    if (rst) begin
      info <= '0;
    end else if (accept) begin
      info.loop_seen <= loop_next;
      if (first_elem) begin
        info.command    <= item.command;
        info.prefix     <= item.prefix_index;
        info.rel        <= rel_clamped;
        info.first_asn  <= item.path_asn;
        info.second_asn <= '0;
      end else if (count == LEN_W'(1)) begin
        info.second_asn <= item.path_asn;
      end
      if (item.last_element) begin
        info.len <= count_inc;
      end
    end
  end

endmodule

>>> rtl/grs_route_decide.sv
// route comparison and table update decision for a finished announcement
module grs_route_decide (
  input  grs_pkg::path_info_t   info,
  input  grs_pkg::route_entry_t cur,
  output logic                  wr_en,
  output grs_pkg::route_entry_t new_entry,
  output grs_pkg::result_t      result
);
  import grs_pkg::*;

  logic [LEN_W-1:0] nlen;
  logic             too_long;
  logic             cand_wins;
  route_entry_t     final_entry;
  logic [2:0]       status;

  assign nlen     = info.len + 1'b1;
  assign too_long = (info.len > LEN_W'(MAX_PATH_LEN));

  // relationship, then length, then neighbor asn
  always_comb begin
    if (cur.rel != info.rel) begin
      cand_wins = (info.rel > cur.rel);
    end else if (cur.len != nlen) begin
      cand_wins = (nlen < cur.len);
    end else begin
      cand_wins = (info.first_asn < cur.nbr);
    end
  end

  // decision
  always_comb begin
    wr_en     = 1'b0;
    new_entry = cur;
    status    = STATUS_KEPT;
    if (info.command == CMD_SEED) begin
      if (cur.valid) begin
        status = STATUS_SEED_CONFL;
      end else if (too_long) begin
        status = STATUS_TOO_LONG;
      end else begin
        wr_en            = 1'b1;
        new_entry.valid  = 1'b1;
        new_entry.seeded = 1'b1;
        new_entry.rel    = info.rel;
        new_entry.len    = info.len;
        new_entry.nbr    = (info.len > LEN_W'(1)) ? info.second_asn : info.first_asn;
        status           = STATUS_SEED_STORED;
      end
    end else if (cur.valid && cur.seeded) begin
      status = STATUS_SEEDED_KEPT;
    end else if (too_long) begin
      status = STATUS_TOO_LONG;
    end else if (info.loop_seen) begin
      status = STATUS_LOOP_DROP;
    end else if (!cur.valid || cand_wins) begin
      wr_en            = 1'b1;
      new_entry.valid  = 1'b1;
      new_entry.seeded = 1'b0;
      new_entry.rel    = info.rel;
      new_entry.len    = nlen;
      new_entry.nbr    = info.first_asn;
      status           = STATUS_NEW_BEST;
    end
  end

  assign final_entry = wr_en ? new_entry : cur;

  // result fields from the entry as it stands after the update
  always_comb begin
    result.result_prefix = info.prefix;
    result.status        = status;
    if (final_entry.valid) begin
      result.best_relationship = final_entry.rel;
      result.best_path_length  = 7'(final_entry.len);
      result.best_neighbor_asn = final_entry.nbr;
    end else begin
      result.best_relationship = REL_NONE;
      result.best_path_length  = '0;
      result.best_neighbor_asn = '0;
    end
  end

endmodule

>>> rtl/gao_rexford_route_selector_unit.sv
// top level of the route selector: control, table access and result register
//
// Each request carries one AS path element; an announcement is a run of
// requests closed by last_element. Elements are taken one per cycle, but
// none while a resolve is pending or the table is being cleared; the route
// table is read when the first element is taken and, if the route changes,
// written back in a resolve step after the last element. The resolve step
// waits only if the previous result has not yet been taken. The table is a
// single RAM with one read and one write port; after reset a clearing pass
// empties it, during which no request is taken (own_asn writes are taken at
// any time).
module gao_rexford_route_selector_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [31:0]      cfg_data,
  input  logic             item_valid,
  output logic             item_ready,
  input  grs_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output grs_pkg::result_t result
);
  import grs_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR   = 3'b001,
    S_COLLECT = 3'b010,
    S_RESOLVE = 3'b100
  } ctrl_state_t;

  ctrl_state_t       state;
  ctrl_state_t       state_next;
  logic [IDX_W-1:0]  clear_idx;
  logic [31:0]       own_asn;
  logic              accept;
  logic              first_elem;
  path_info_t        info;
  route_entry_t      cur_entry;
  route_entry_t      new_entry;
  logic              upd_en;
  result_t           upd_result;
  logic              resolve_go;
  logic              ram_wr_en;
  logic [IDX_W-1:0]  ram_wr_addr;
  route_entry_t      ram_wr_data;

  // configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      own_asn <= '0;
    end else if (cfg_valid) begin
      own_asn <= cfg_data;
    end
  end

  assign item_ready = (state == S_COLLECT);
  assign accept     = item_valid && item_ready;
  assign resolve_go = (state == S_RESOLVE) && (!result_valid || result_ready);

  // control state machine
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clear_idx == IDX_W'(PREFIX_COUNT - 1)) state_next = S_COLLECT;
      end
      S_COLLECT: begin
        if (accept && item.last_element) state_next = S_RESOLVE;
      end
      S_RESOLVE: begin
        if (resolve_go) state_next = S_COLLECT;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clear_idx <= '0;
    end else if (state == S_CLEAR) begin
      clear_idx <= clear_idx + 1'b1;
    end
  end

  grs_path_collector u_collector (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .item       (item),
    .own_asn    (own_asn),
    .first_elem (first_elem),
    .info       (info)
  );

  // table write mux: clearing pass or resolve write-back
  always_comb begin
    if (state == S_CLEAR) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = clear_idx;
      ram_wr_data = '0;
    end else begin
      ram_wr_en   = resolve_go && upd_en;
      ram_wr_addr = info.prefix[IDX_W-1:0];
      ram_wr_data = new_entry;
    end
  end

  grs_route_ram u_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (accept && first_elem),
    .rd_addr (item.prefix_index[IDX_W-1:0]),
    .rd_data (cur_entry)
  );

  grs_route_decide u_decide (
    .info      (info),
    .cur       (cur_entry),
    .wr_en     (upd_en),
    .new_entry (new_entry),
    .result    (upd_result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (resolve_go) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (resolve_go) begin
      result <= upd_result;
    end
  end

endmodule

>>> tb/gao_rexford_route_selector_unit_tb.sv
// testbench of the route selector: random and directed announcements checked against a predictor
`timescale 1ns / 100ps

module gao_rexford_route_selector_unit_tb;
  import grs_pkg::*;

  // route held per prefix by the predictor
  typedef struct {
    bit          valid;
    bit          seeded;
    logic [2:0]  rel;
    int unsigned len;
    logic [31:0] nbr;
  } route_model_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;
  logic        item_valid = 1'b0;
  logic        item_ready;
  item_t       item = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  result_t     result;

  // handshakes seen at the last rising edge
  logic req_accepted = 1'b0;
  logic result_accepted = 1'b0;
  logic cfg_accepted = 1'b0;

  item_t       pending_requests [$];
  result_t     expected_outcomes [$];
  logic [31:0] path_buf [$];

  // predictor state
  route_model_t routes [PREFIX_COUNT];
  int unsigned  path_count;
  bit           loop_flag;
  logic [31:0]  first_asn;
  logic [31:0]  second_asn;
  logic [31:0]  own_asn_model;
  logic         held_cmd;
  logic [9:0]   held_pfx;
  logic [2:0]   held_rel;

  // stimulus controls
  logic [31:0] cur_asn;
  bit          send_idle;
  bit          recv_idle;
  int unsigned stall_asks;
  int unsigned stall_done;
  int unsigned send_wait;
  int unsigned ready_wait;
  int unsigned hold_left;

  // bookkeeping
  int unsigned mismatch_count;
  int unsigned element_total;
  int unsigned announcements;
  int unsigned results_checked;
  int unsigned asn_settings;
  int unsigned status_seen [7];

  gao_rexford_route_selector_unit uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what);
    if (mismatch_count < 100) begin
      $display("mismatch at %0t: %s", $realtime, what);
    end
    mismatch_count++;
  endtask

  // predictor: one path element in, at most one expected outcome queued
  function automatic void select_route(input item_t req);
    result_t     r;
    logic [2:0]  st;
    int unsigned n;
    int unsigned slot;
    int unsigned nlen;
    bit          wins;
    if (path_count == 0) begin
      held_cmd   = req.command;
      held_pfx   = req.prefix_index;
      if (req.relationship < REL_PROVIDER) held_rel = REL_PROVIDER;
      else if (req.relationship > REL_ORIGIN) held_rel = REL_ORIGIN;
      else held_rel = req.relationship;
      loop_flag  = 1'b0;
      first_asn  = req.path_asn;
      second_asn = '0;
    end else if (path_count == 1) begin
      second_asn = req.path_asn;
    end
    if (req.path_asn == own_asn_model) loop_flag = 1'b1;
    if (path_count <= MAX_PATH_LEN) path_count++;
    if (!req.last_element) return;

    n = path_count;
    path_count = 0;
    slot = held_pfx % PREFIX_COUNT;

    // seed announcement
    if (held_cmd == CMD_SEED) begin
      if (routes[slot].valid) begin
        st = STATUS_SEED_CONFL;
      end else if (n > MAX_PATH_LEN) begin
        st = STATUS_TOO_LONG;
      end else begin
        routes[slot].valid  = 1'b1;
        routes[slot].seeded = 1'b1;
        routes[slot].rel    = held_rel;
        routes[slot].len    = n;
        routes[slot].nbr    = (n > 1) ? second_asn : first_asn;
        st = STATUS_SEED_STORED;
      end
    // received announcement
    end else if (routes[slot].valid && routes[slot].seeded) begin
      st = STATUS_SEEDED_KEPT;
    end else if (n > MAX_PATH_LEN) begin
      st = STATUS_TOO_LONG;
    end else if (loop_flag) begin
      st = STATUS_LOOP_DROP;
    end else begin
      nlen = n + 1;
      if (!routes[slot].valid) wins = 1'b1;
      else if (held_rel != routes[slot].rel) wins = held_rel > routes[slot].rel;
      else if (nlen != routes[slot].len) wins = nlen < routes[slot].len;
      else wins = first_asn < routes[slot].nbr;
      if (wins) begin
        routes[slot].valid  = 1'b1;
        routes[slot].seeded = 1'b0;
        routes[slot].rel    = held_rel;
        routes[slot].len    = nlen;
        routes[slot].nbr    = first_asn;
        st = STATUS_NEW_BEST;
      end else begin
        st = STATUS_KEPT;
      end
    end

    r.result_prefix = held_pfx;
    r.status        = st;
    if (routes[slot].valid) begin
      r.best_relationship = routes[slot].rel;
      r.best_path_length  = 7'(routes[slot].len);
      r.best_neighbor_asn = routes[slot].nbr;
    end else begin
      r.best_relationship = REL_NONE;
      r.best_path_length  = '0;
      r.best_neighbor_asn = '0;
    end
    expected_outcomes = {expected_outcomes, r};
  endfunction

  // compare one outcome against the oldest expectation
  task automatic check_outcome(input result_t got);
    result_t want;
    if (expected_outcomes.size() == 0) begin
      report_mismatch($sformatf("unexpected result prefix %0d status %0d",
                                got.result_prefix, got.status));
      return;
    end
    want = expected_outcomes.pop_front();
    results_checked++;
    status_seen[want.status]++;
    if (got.result_prefix !== want.result_prefix)
      report_mismatch($sformatf("prefix %0d, want %0d", got.result_prefix, want.result_prefix));
    if (got.status !== want.status)
      report_mismatch($sformatf("prefix %0d status %0d, want %0d",
                                want.result_prefix, got.status, want.status));
    if (got.best_relationship !== want.best_relationship)
      report_mismatch($sformatf("prefix %0d relationship %0d, want %0d", want.result_prefix,
                                got.best_relationship, want.best_relationship));
    if (got.best_path_length !== want.best_path_length)
      report_mismatch($sformatf("prefix %0d path length %0d, want %0d", want.result_prefix,
                                got.best_path_length, want.best_path_length));
    if (got.best_neighbor_asn !== want.best_neighbor_asn)
      report_mismatch($sformatf("prefix %0d neighbor %h, want %h", want.result_prefix,
                                got.best_neighbor_asn, want.best_neighbor_asn));
  endtask

  // monitor: sample every handshake at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      req_accepted    <= 1'b0;
      result_accepted <= 1'b0;
      cfg_accepted    <= 1'b0;
    end else begin
      req_accepted    <= item_valid && item_ready;
      result_accepted <= result_valid && result_ready;
      cfg_accepted    <= cfg_valid && cfg_ready;
      if (cfg_valid && cfg_ready) own_asn_model = cfg_data;
      if (item_valid && item_ready) begin
        element_total++;
        select_route(item);
      end
      if (result_valid && result_ready) check_outcome(result);
    end
  end

  // request driver: fed from the pending queue, random gap after each request if send_idle is set
  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      send_wait = 0;
    end else if (!item_valid || req_accepted) begin
      if (req_accepted) send_wait = send_idle ? $urandom_range(0, 5) : 0;
      if (send_wait != 0) begin
        send_wait--;
        item_valid <= 1'b0;
      end else if (pending_requests.size() != 0) begin
        item       <= pending_requests.pop_front();
        item_valid <= 1'b1;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // result receiver: random stalls if recv_idle is set, plus an occasional long hold-off
  always @(negedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
      ready_wait = 0;
      hold_left = 0;
    end else begin
      if (result_accepted) ready_wait = recv_idle ? $urandom_range(0, 5) : 0;
      if (stall_asks != stall_done) begin
        stall_done++;
        hold_left = 300;
      end
      if (hold_left != 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else if (ready_wait != 0) begin
        ready_wait--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  task automatic write_own_asn(input logic [31:0] value);
    @(negedge clk);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(negedge clk); while (!cfg_accepted);
    cfg_valid <= 1'b0;
    cur_asn = value;
    asn_settings++;
  endtask

  // wait until every request is sent and every outcome has come back
  task automatic wait_drained();
    while (!(pending_requests.size() == 0 && !item_valid && expected_outcomes.size() == 0))
      @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  // queue the announcement in path_buf; later elements carry junk in latched fields
  task automatic queue_path(input logic cmd, input logic [9:0] pfx, input logic [2:0] rel);
    item_t req;
    foreach (path_buf[k]) begin
      req.command      = (k == 0) ? cmd : 1'($urandom_range(0, 1));
      req.prefix_index = (k == 0) ? pfx : 10'($urandom_range(0, 1023));
      req.relationship = (k == 0) ? rel : 3'($urandom_range(0, 7));
      req.path_asn     = path_buf[k];
      req.last_element = (k == path_buf.size() - 1);
      pending_requests = {pending_requests, req};
    end
    announcements++;
  endtask

  function automatic void fill_span(input int unsigned n, input logic [31:0] base);
    path_buf.delete();
    for (int unsigned k = 0; k < n; k++) path_buf = {path_buf, base + k};
  endfunction

  // asn mix: own asn for loops, small pool for ties, extremes and full range
  function automatic logic [31:0] pick_asn();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 8) return cur_asn;
    else if (sel < 14) return 32'h0000_0000;
    else if (sel < 20) return 32'hFFFF_FFFF;
    else if (sel < 60) return 32'($urandom_range(1, 12));
    else return $urandom();
  endfunction

  task automatic run_random_phase(input logic [31:0] asn, input bit s_idle, input bit r_idle,
                                  input bit stall, input int unsigned n_elements);
    int unsigned added;
    int unsigned n;
    int unsigned sel;
    logic        cmd;
    logic [9:0]  pfx;
    logic [2:0]  rel;
    write_own_asn(asn);
    send_idle = s_idle;
    recv_idle = r_idle;
    added = 0;
    while (added < n_elements) begin
      cmd = ($urandom_range(0, 99) < 8) ? CMD_SEED : CMD_RECEIVED;
      sel = $urandom_range(0, 99);
      if (sel < 75) pfx = 10'($urandom_range(0, 23));
      else if (sel < 85) pfx = 10'($urandom_range(1016, 1023));
      else pfx = 10'($urandom_range(0, 1023));
      rel = 3'($urandom_range(0, 7));
      n = ($urandom_range(0, 99) < 3) ? $urandom_range(62, 70) : $urandom_range(1, 6);
      path_buf.delete();
      repeat (n) path_buf = {path_buf, pick_asn()};
      queue_path(cmd, pfx, rel);
      added += n;
    end
    if (stall) stall_asks++;
    wait_drained();
  endtask

  // run limit
  initial begin
    #5_000_000;
    $display("gao_rexford_route_selector_unit_tb: errors");
    $finish;
  end

  // stimulus
  initial begin
    foreach (routes[k]) routes[k] = '{default: 0};
    path_count = 0;
    loop_flag = 1'b0;
    first_asn = '0;
    second_asn = '0;
    own_asn_model = '0;
    held_cmd = CMD_RECEIVED;
    held_pfx = '0;
    held_rel = REL_NONE;
    cur_asn = '0;
    send_idle = 1'b0;
    recv_idle = 1'b0;
    stall_asks = 0;
    stall_done = 0;
    mismatch_count = 0;
    element_total = 0;
    announcements = 0;
    results_checked = 0;
    asn_settings = 0;
    foreach (status_seen[k]) status_seen[k] = 0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: route ordering, clamping, seeds, loops, length limits
    write_own_asn(32'd100);
    recv_idle = 1'b1;
    path_buf = '{32'd7};                queue_path(CMD_RECEIVED, 10'd5, 3'd1);
    path_buf = '{32'd9, 32'd10};        queue_path(CMD_RECEIVED, 10'd5, 3'd2);
    path_buf = '{32'd3};                queue_path(CMD_RECEIVED, 10'd5, 3'd2);
    path_buf = '{32'd8};                queue_path(CMD_RECEIVED, 10'd5, 3'd2);
    path_buf = '{32'd2};                queue_path(CMD_RECEIVED, 10'd5, 3'd2);
    path_buf = '{32'd2};                queue_path(CMD_RECEIVED, 10'd5, 3'd2);
    path_buf = '{32'd100};              queue_path(CMD_RECEIVED, 10'd6, 3'd0);
    path_buf = '{32'd4};                queue_path(CMD_RECEIVED, 10'd6, 3'd0);
    path_buf = '{32'd5, 32'd100, 32'd6}; queue_path(CMD_RECEIVED, 10'd3, 3'd3);
    path_buf = '{32'd11, 32'd12};       queue_path(CMD_SEED, 10'd7, 3'd7);
    path_buf = '{32'd13};               queue_path(CMD_SEED, 10'd8, 3'd3);
    path_buf = '{32'd1};                queue_path(CMD_RECEIVED, 10'd7, 3'd4);
    path_buf = '{32'd14};               queue_path(CMD_SEED, 10'd5, 3'd4);
    path_buf = '{32'd100, 32'd20};      queue_path(CMD_SEED, 10'd10, 3'd2);
    path_buf = '{32'hFFFF_FFFF, 32'h0}; queue_path(CMD_RECEIVED, 10'd2, 3'd6);
    path_buf = '{32'h0};                queue_path(CMD_RECEIVED, 10'd2, 3'd6);
    // path length limits, with saturation and check order
    fill_span(65, 32'd1000);            queue_path(CMD_SEED, 10'd1023, 3'd2);
    fill_span(65, 32'd1000);            queue_path(CMD_RECEIVED, 10'd0, 3'd3);
    fill_span(64, 32'd1000);            queue_path(CMD_RECEIVED, 10'd0, 3'd3);
    fill_span(64, 32'd2000);            queue_path(CMD_SEED, 10'd9, 3'd1);
    fill_span(70, 32'd3000);
    path_buf[10] = 32'd100;             queue_path(CMD_RECEIVED, 10'd1023, 3'd5);
    fill_span(66, 32'd4000);            queue_path(CMD_RECEIVED, 10'd7, 3'd4);
    path_buf = '{32'd1};                queue_path(CMD_RECEIVED, 10'd1023, 3'd4);
    wait_drained();

    // random phases over several own asn settings and idling patterns
    run_random_phase(32'h0000_0000, 1'b0, 1'b0, 1'b0, 40);
    run_random_phase(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 40);
    run_random_phase($urandom(), 1'b1, 1'b0, 1'b1, 40);
    run_random_phase(32'd3, 1'b0, 1'b1, 1'b0, 40);
    run_random_phase(32'($urandom_range(1, 12)), 1'b1, 1'b1, 1'b1, 40);

    $display("covered %0d path elements in %0d announcements over %0d own asn settings",
             element_total, announcements, asn_settings);
    $display({"%0d outcomes: %0d new best, %0d kept, %0d loop, %0d seeded kept, ",
              "%0d seed stored, %0d conflict, %0d too long"},
             results_checked, status_seen[STATUS_NEW_BEST], status_seen[STATUS_KEPT],
             status_seen[STATUS_LOOP_DROP], status_seen[STATUS_SEEDED_KEPT],
             status_seen[STATUS_SEED_STORED], status_seen[STATUS_SEED_CONFL],
             status_seen[STATUS_TOO_LONG]);
    if (mismatch_count == 0) begin
      $display("gao_rexford_route_selector_unit_tb: clean");
    end else begin
      $display("gao_rexford_route_selector_unit_tb: errors");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/grs_pkg.sv
rtl/grs_route_ram.sv
rtl/grs_path_collector.sv
rtl/grs_route_decide.sv
rtl/gao_rexford_route_selector_unit.sv
tb/gao_rexford_route_selector_unit_tb.sv
